// ----- src/assert_macros.svh -----
// Assertion macros shared by the priority task queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define PTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: the consequent is checked in the cycle after the antecedent.
`define PTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ptq_pkg.sv -----
// Types and constants of the priority task queue.
package ptq_pkg;

  localparam int unsigned ID_W      = 8;
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned PATH_W    = 64;
  localparam int unsigned WORKERS_W = 4;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned STATUS_W  = 3;

  // claim skips an entry already holding this many workers
  localparam logic [WORKERS_W-1:0] MaxWorkers = 4'd8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CLAIM  = 2'd1,
    OP_FINISH = 2'd2,
    OP_REMOVE = 2'd3
  } ptq_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_NONE      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_BUSY      = 3'd4
  } ptq_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_PLACE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } ptq_state_e;

  typedef struct packed {
    logic [DEPTH_W-1:0]   depth;
    logic [PATH_W-1:0]    path;
    logic [ID_W-1:0]      task_id;
    logic                 active;
    logic [WORKERS_W-1:0] workers;
  } ptq_entry_t;

  // verdicts of the compare unit on one stored entry
  typedef struct packed {
    logic precedes;   // new key sorts strictly ahead of the entry
    logic id_hit;     // entry holds the requested id
    logic claimable;  // active and below the worker limit
    logic busy;       // workers still attached
  } ptq_flags_t;

endpackage

// ----- src/ptq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ptq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ptq_cmp.sv -----
// Shared compare unit: key order, id match and claim test on one entry.
module ptq_cmp (
  input  ptq_pkg::ptq_entry_t           entry_i,
  input  logic [ptq_pkg::DEPTH_W-1:0]   key_depth_i,
  input  logic [ptq_pkg::PATH_W-1:0]    key_path_i,
  input  logic [ptq_pkg::ID_W-1:0]      task_id_i,
  output ptq_pkg::ptq_flags_t           flags_o
);
  import ptq_pkg::*;

  logic depth_eq;

  assign depth_eq = (key_depth_i == entry_i.depth);

  always_comb begin
    // path is packed most significant level first, so an unsigned compare
    // gives the level-by-level order
    flags_o.precedes  = depth_eq ? (key_path_i < entry_i.path)
                                 : (key_depth_i < entry_i.depth);
    flags_o.id_hit    = (entry_i.task_id == task_id_i);
    flags_o.claimable = entry_i.active && (entry_i.workers < MaxWorkers);
    flags_o.busy      = (entry_i.workers != '0);
  end

endmodule

// ----- src/priority_task_queue_unit.sv -----
// Priority task queue: a sorted store of up to QUEUE_DEPTH tasks in one entry RAM,
// walked by a single compare unit. Entries are visited one at a time: insert walks
// back from the tail moving entries up until its slot, claim and finish scan from
// the head, and remove scans then moves every later entry down by one. The pace is
// set by the RAM's single read port with its registered read. The input is not
// ready while a word is in work; a finished result waits in the output register
// and does not hold off the next input word.
module priority_task_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // task_id[7:0], key_depth[23:8], key_path[87:24]
  input  logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // result_task[7:0], now_idle[8], occupancy[13:9], 0
  output logic [2:0]  m_axis_tuser    // status[2:0]
);
  import ptq_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] QDepth = CW'(QUEUE_DEPTH);

  ptq_state_e state_q, state_d;
  ptq_op_e    op_q, op_d;
  logic [ID_W-1:0]      id_q, id_d;
  logic [DEPTH_W-1:0]   depth_q, depth_d;
  logic [PATH_W-1:0]    path_q, path_d;
  logic [CW-1:0]        idx_q, idx_d, count_q, count_d;
  logic [CW-1:0]        idx_inc, idx_dec;
  ptq_status_e          status_q, status_d;
  logic [ID_W-1:0]      rtask_q, rtask_d;
  logic                 idle_q, idle_d;

  logic                 m_valid_q;
  ptq_status_e          m_status_q;
  logic [ID_W-1:0]      m_task_q;
  logic                 m_idle_q;
  logic [OCC_W-1:0]     m_occ_q;
  logic                 out_free;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  ptq_entry_t           ram_wdata, ram_rdata, new_entry;
  ptq_flags_t           flags;

  ptq_ram #(
    .WIDTH ($bits(ptq_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptq_cmp u_cmp (
    .entry_i     (ram_rdata),
    .key_depth_i (depth_q),
    .key_path_i  (path_q),
    .task_id_i   (id_q),
    .flags_o     (flags)
  );

  assign idx_inc  = idx_q + 1'b1;
  assign idx_dec  = idx_q - 1'b1;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    new_entry.depth   = depth_q;
    new_entry.path    = path_q;
    new_entry.task_id = id_q;
    new_entry.active  = 1'b1;
    new_entry.workers = '0;
  end

  // next state
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    id_d     = id_q;
    depth_d  = depth_q;
    path_d   = path_q;
    idx_d    = idx_q;
    count_d  = count_q;
    status_d = status_q;
    rtask_d  = rtask_q;
    idle_d   = idle_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = ptq_op_e'(s_axis_tuser);
          id_d     = s_axis_tdata[7:0];
          depth_d  = s_axis_tdata[23:8];
          path_d   = s_axis_tdata[87:24];
          status_d = STS_OK;
          rtask_d  = s_axis_tdata[7:0];
          idle_d   = 1'b0;
          idx_d    = '0;
          if (ptq_op_e'(s_axis_tuser) == OP_INSERT) begin
            if (count_q >= QDepth) begin
              status_d = STS_FULL;
              state_d  = ST_DONE;
            end else begin
              idx_d   = count_q;
              state_d = (count_q == '0) ? ST_PLACE : ST_READ;
            end
          end else if (count_q == '0) begin
            if (ptq_op_e'(s_axis_tuser) == OP_CLAIM) begin
              status_d = STS_NONE;
              rtask_d  = '0;
            end else begin
              status_d = STS_NOT_FOUND;
            end
            state_d = ST_DONE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        case (op_q)
          OP_INSERT: begin
            if (flags.precedes) begin
              idx_d   = idx_dec;
              state_d = (idx_dec == '0) ? ST_PLACE : ST_READ;
            end else begin
              count_d = count_q + 1'b1;
              state_d = ST_DONE;
            end
          end
          OP_CLAIM: begin
            if (flags.claimable) begin
              rtask_d = ram_rdata.task_id;
              state_d = ST_DONE;
            end else if (idx_inc == count_q) begin
              status_d = STS_NONE;
              rtask_d  = '0;
              state_d  = ST_DONE;
            end else begin
              idx_d   = idx_inc;
              state_d = ST_READ;
            end
          end
          OP_FINISH: begin
            if (flags.id_hit) begin
              idle_d  = (ram_rdata.workers == WORKERS_W'(1));
              state_d = ST_DONE;
            end else if (idx_inc == count_q) begin
              status_d = STS_NOT_FOUND;
              state_d  = ST_DONE;
            end else begin
              idx_d   = idx_inc;
              state_d = ST_READ;
            end
          end
          OP_REMOVE: begin
            if (flags.id_hit) begin
              if (flags.busy) begin
                status_d = STS_BUSY;
                state_d  = ST_DONE;
              end else if (idx_inc == count_q) begin
                count_d = count_q - 1'b1;
                state_d = ST_DONE;
              end else begin
                state_d = ST_SHIFT_RD;
              end
            end else if (idx_inc == count_q) begin
              status_d = STS_NOT_FOUND;
              state_d  = ST_DONE;
            end else begin
              idx_d   = idx_inc;
              state_d = ST_READ;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_PLACE: begin
        count_d = count_q + 1'b1;
        state_d = ST_DONE;
      end
      ST_SHIFT_RD: state_d = ST_SHIFT_WR;
      ST_SHIFT_WR: begin
        idx_d = idx_inc;
        if (idx_inc + 1'b1 == count_q) begin
          count_d = count_q - 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SHIFT_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // RAM control and input handshake
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx_q[IW-1:0];
    ram_wdata     = new_entry;
    ram_raddr     = idx_q[IW-1:0];
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_READ: begin
        if (op_q == OP_INSERT) begin
          ram_raddr = idx_dec[IW-1:0];
        end
      end
      ST_EVAL: begin
        case (op_q)
          OP_INSERT: begin
            // entry moves up one slot, or the new word lands above it
            ram_we    = 1'b1;
            ram_wdata = flags.precedes ? ram_rdata : new_entry;
          end
          OP_CLAIM: begin
            ram_we            = flags.claimable;
            ram_wdata         = ram_rdata;
            ram_wdata.workers = ram_rdata.workers + 1'b1;
          end
          OP_FINISH: begin
            ram_we           = flags.id_hit;
            ram_wdata        = ram_rdata;
            ram_wdata.active = 1'b0;
            if (flags.busy) begin
              ram_wdata.workers = ram_rdata.workers - 1'b1;
            end
          end
          default: ram_we = 1'b0;
        endcase
      end
      ST_PLACE: ram_we = 1'b1;
      ST_SHIFT_RD: ram_raddr = idx_inc[IW-1:0];
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    depth_q  <= depth_d;
    path_q   <= path_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    rtask_q  <= rtask_d;
    idle_q   <= idle_d;
    if (state_q == ST_DONE && out_free) begin
      m_status_q <= status_q;
      m_task_q   <= rtask_q;
      m_idle_q   <= idle_q;
      m_occ_q    <= OCC_W'(count_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {2'b00, m_occ_q, m_idle_q, m_task_q};

  `PTQ_ASSERT(a_count_bound, count_q <= QDepth, "entry count above queue depth")
  `PTQ_ASSERT(a_count_step,
    (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1) ||
    (count_q + 1'b1 == $past(count_q)), "entry count moved by more than one")
  `PTQ_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "input accepted twice in a row")
  `PTQ_ASSERT_NEXT(a_result_loaded, state_q == ST_DONE && out_free, m_axis_tvalid,
    "finished result not presented")

endmodule

// ----- sim/priority_task_queue_unit_test.sv -----
// Self-checking testbench of the priority task queue: directed and random words, scoreboard.
module priority_task_queue_unit_test;
  import ptq_pkg::*;

  localparam int unsigned QDEPTH      = 16;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 48;
  localparam int unsigned ITEMS       = 2000;

  typedef enum int unsigned {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] task_id;
    logic       idle;
    logic [4:0] occ;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;   // task_id[7:0], key_depth[23:8], key_path[87:24]
  logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // result_task[7:0], now_idle[8], occupancy[13:9], 0
  logic [2:0]  m_axis_tuser;        // status[2:0]

  bit steady = 1'b0;

  // Sorted task store mirrored word by word; holds the replies still owed by the block.
  class reply_board;
    logic [15:0] depth_q[QDEPTH];
    logic [63:0] path_q[QDEPTH];
    logic [7:0]  id_q[QDEPTH];
    bit          active_q[QDEPTH];
    logic [3:0]  workers_q[QDEPTH];
    int unsigned count;
    reply_t      replies_due[$];
    int unsigned faults;

    function new();
      count  = 0;
      faults = 0;
      foreach (active_q[i]) begin
        active_q[i]  = 1'b0;
        workers_q[i] = '0;
      end
    endfunction

    function int unsigned first_hit(logic [7:0] id);
      int unsigned i;
      i = 0;
      while (i < count && id_q[i] != id) i++;
      return i;
    endfunction

    function logic [7:0] held_id();
      if (count == 0) return 8'($urandom_range(0, 15));
      return id_q[$urandom_range(0, count - 1)];
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function void note_word(ptq_op_e op, logic [7:0] id, logic [15:0] kd, logic [63:0] kp);
      reply_t      r;
      int unsigned pos;
      int unsigned i;
      r.status  = STS_OK;
      r.task_id = id;
      r.idle    = 1'b0;
      case (op)
        OP_INSERT: begin
          if (count >= QDEPTH) begin
            r.status = STS_FULL;
          end else begin
            // equal keys stay ahead of the newcomer
            pos = 0;
            while (pos < count &&
                   !(kd < depth_q[pos] || (kd == depth_q[pos] && kp < path_q[pos]))) pos++;
            for (i = count; i > pos; i--) begin
              depth_q[i]   = depth_q[i-1];
              path_q[i]    = path_q[i-1];
              id_q[i]      = id_q[i-1];
              active_q[i]  = active_q[i-1];
              workers_q[i] = workers_q[i-1];
            end
            depth_q[pos]   = kd;
            path_q[pos]    = kp;
            id_q[pos]      = id;
            active_q[pos]  = 1'b1;
            workers_q[pos] = '0;
            count++;
          end
        end
        OP_CLAIM: begin
          i = 0;
          while (i < count && !(active_q[i] && workers_q[i] < MaxWorkers)) i++;
          if (i < count) begin
            workers_q[i] = workers_q[i] + 4'd1;
            r.task_id    = id_q[i];
          end else begin
            r.status  = STS_NONE;
            r.task_id = '0;
          end
        end
        OP_FINISH: begin
          i = first_hit(id);
          if (i >= count) begin
            r.status = STS_NOT_FOUND;
          end else begin
            active_q[i] = 1'b0;
            if (workers_q[i] != 0) begin
              workers_q[i] = workers_q[i] - 4'd1;
              r.idle = (workers_q[i] == 0);
            end
          end
        end
        default: begin
          i = first_hit(id);
          if (i >= count) begin
            r.status = STS_NOT_FOUND;
          end else if (workers_q[i] != 0) begin
            r.status = STS_BUSY;
          end else begin
            for (; i + 1 < count; i++) begin
              depth_q[i]   = depth_q[i+1];
              path_q[i]    = path_q[i+1];
              id_q[i]      = id_q[i+1];
              active_q[i]  = active_q[i+1];
              workers_q[i] = workers_q[i+1];
            end
            count--;
            active_q[count]  = 1'b0;
            workers_q[count] = '0;
          end
        end
      endcase
      r.occ = 5'(count);
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [2:0] status, logic [7:0] rtask, logic idle,
                              logic [4:0] occ);
      reply_t want;
      if (replies_due.size() == 0) begin
        fault($sformatf("reply with none pending: status %0d task %0d idle %0b occ %0d",
                        status, rtask, idle, occ));
        return;
      end
      want = replies_due.pop_front();
      if (status !== want.status)
        fault($sformatf("status exp %0d got %0d", want.status, status));
      if (rtask !== want.task_id)
        fault($sformatf("result_task exp %0d got %0d", want.task_id, rtask));
      if (idle !== want.idle)
        fault($sformatf("now_idle exp %0b got %0b", want.idle, idle));
      if (occ !== want.occ)
        fault($sformatf("occupancy exp %0d got %0d", want.occ, occ));
    endfunction
  endclass

  reply_board sb = new();

  priority_task_queue_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready)
      sb.check_reply(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[13:9]);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
          (m_axis_tvalid === 1'b1 && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("priority_task_queue_unit_test: errors");
    $finish;
  end

  // Called at a rising edge; returns at the edge where the word was taken.
  task automatic send_word(input ptq_op_e op, input logic [7:0] id, input logic [15:0] kd,
                           input logic [63:0] kp);
    int unsigned gap;
    if (!steady && $urandom_range(0, 99) < 12) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {kp, kd, id};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_word(op, id, kd, kp);
  endtask

  initial begin : stimulus
    mix_e        mix;
    int unsigned pick;
    int unsigned n;
    ptq_op_e     op;
    logic [7:0]  id;
    logic [15:0] kd;
    logic [63:0] kp;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store: nothing to claim, ids absent
    send_word(OP_CLAIM,  8'hA5, '0, '0);
    send_word(OP_FINISH, 8'h5A, '0, '0);
    send_word(OP_REMOVE, 8'h5A, '0, '0);
    // key extremes, ties and a duplicate id
    send_word(OP_INSERT, 8'hFF, 16'hFFFF, '1);
    send_word(OP_INSERT, 8'h00, 16'h0000, '0);
    send_word(OP_INSERT, 8'h01, 16'h0000, '0);
    send_word(OP_INSERT, 8'h01, 16'h0000, 64'd1);
    send_word(OP_INSERT, 8'h80, 16'hFFFF, '1);
    // head fills up to the worker limit, the ninth claim skips to the next entry
    repeat (9) send_word(OP_CLAIM, 8'($urandom), '0, '0);
    send_word(OP_REMOVE, 8'h00, '0, '0);
    send_word(OP_FINISH, 8'h00, '0, '0);
    send_word(OP_FINISH, 8'h01, '0, '0);
    send_word(OP_FINISH, 8'h80, '0, '0);
    send_word(OP_REMOVE, 8'h80, '0, '0);
    send_word(OP_REMOVE, 8'h01, '0, '0);
    send_word(OP_INSERT, 8'h7F, 16'h8000, 64'h8000_0000_0000_0000);

    mix = MIX_FILL;
    for (n = 0; n < ITEMS; n++) begin
      if (n % 100 == 0) begin
        mix    = mix_e'($urandom_range(0, 2));
        steady = (n >= 800 && n < 1000);
      end
      pick = $urandom_range(0, 99);
      case (mix)
        MIX_FILL:  op = (pick < 60) ? OP_INSERT : (pick < 80) ? OP_CLAIM :
                        (pick < 92) ? OP_FINISH : OP_REMOVE;
        MIX_DRAIN: op = (pick < 15) ? OP_INSERT : (pick < 30) ? OP_CLAIM :
                        (pick < 65) ? OP_FINISH : OP_REMOVE;
        default:   op = (pick < 35) ? OP_INSERT : (pick < 60) ? OP_CLAIM :
                        (pick < 80) ? OP_FINISH : OP_REMOVE;
      endcase

      // mostly ids that are held, so finish and remove find their task
      pick = $urandom_range(0, 99);
      if (op == OP_INSERT)
        id = (pick < 70) ? 8'($urandom_range(0, 15)) : 8'($urandom);
      else
        id = (pick < 80) ? sb.held_id() : 8'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 40)      kd = 16'($urandom_range(0, 3));
      else if (pick < 60) kd = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else                kd = 16'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 30)      kp = 64'($urandom_range(0, 3));
      else if (pick < 50) kp = {16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
                                16'($urandom_range(0, 2)), 16'($urandom_range(0, 2))};
      else if (pick < 60) kp = $urandom_range(0, 1) ? '1 : '0;
      else                kp = {$urandom, $urandom};

      send_word(op, id, kd, kp);
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.faults == 0 && sb.pending() == 0)
      $display("priority_task_queue_unit_test: clean");
    else
      $display("priority_task_queue_unit_test: errors");
    $finish;
  end

endmodule

// ----- priority_task_queue_unit.f -----
+incdir+src
src/ptq_pkg.sv
src/ptq_ram.sv
src/ptq_cmp.sv
src/priority_task_queue_unit.sv
sim/priority_task_queue_unit_test.sv
